FILE: rtl/core/rmq_pkg.sv
// rmq_pkg: widths, word types and side-band structs for the rotation matrix to
// quaternion pipeline. No dependencies; used by every file in rtl/core.
`default_nettype none

package rmq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int SCALE_BITS = 10;
  localparam int ELEM_W     = 16;
  localparam int LANES      = 4;
  // signed width of trace and terms, magnitude width of a term
  localparam int TERM_W     = ELEM_W + 4;
  localparam int MAG_W      = ELEM_W + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int RAD_W      = SUM_W + 2 * SCALE_BITS;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int Q_W        = 16;
  localparam int NUM_W      = ROOT_W + Q_W;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [Q_W-1:0]   quo_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_00;
    logic signed [ELEM_W-1:0] elem_01;
    logic signed [ELEM_W-1:0] elem_02;
    logic signed [ELEM_W-1:0] elem_10;
    logic signed [ELEM_W-1:0] elem_11;
    logic signed [ELEM_W-1:0] elem_12;
    logic signed [ELEM_W-1:0] elem_20;
    logic signed [ELEM_W-1:0] elem_21;
    logic signed [ELEM_W-1:0] elem_22;
  } in_word_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] quat_x;
    logic signed [ELEM_W-1:0] quat_y;
    logic signed [ELEM_W-1:0] quat_z;
    logic signed [ELEM_W-1:0] quat_w;
    logic                     degenerate;
  } out_word_t;

  // travels alongside the root extraction
  typedef struct packed {
    logic [LANES-1:0]       neg;
    mag_t [LANES-1:0]       mag;
    logic                   degen;
  } term_side_t;

  // travels alongside the division
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             degen;
  } sign_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: Shepperd matrix to quaternion, Q1.14 in and out.
// Depends on rmq_pkg, rmq_isqrt, rmq_div.
//
//  channel | direction | handshake          | word
//  in      | input     | valid_i / stall_o  | in_word_t  (nine matrix elements)
//  out     | output    | valid_o / stall_i  | out_word_t (x, y, z, w, degenerate)
//
// One word per cycle while the output is not stalled; stages: input, terms, squares,
// sum, 28 root stages, dividend, 16 quotient stages, output register.
// Reset clears only the valid bits of every stage.
// A stalled output word freezes the whole pipeline; bubbles still move up
// while the output register is empty.
`default_nettype none

module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           stall_o,
  input  wire in_word_t  in_i,
  output logic           valid_o,
  input  wire logic      stall_i,
  output out_word_t      out_o
);

  localparam int NUM_SH = FRAC_BITS + SCALE_BITS;

  logic en;

  // stage 1: input register
  logic     s1_v_q;
  in_word_t s1_q;
  // stage 2: terms
  logic             s2_v_q;
  logic [LANES-1:0] s2_neg_q;
  mag_t [LANES-1:0] s2_mag_q;
  // stage 3: squares
  logic                        s3_v_q;
  logic [LANES-1:0]            s3_neg_q;
  mag_t [LANES-1:0]            s3_mag_q;
  logic [LANES-1:0][SQ_W-1:0]  s3_sq_q;
  // stage 4: sum of squares
  logic             s4_v_q;
  logic [SUM_W-1:0] s4_sum_q;
  term_side_t       s4_side_q;
  // root
  logic              rt_v;
  logic [ROOT_W-1:0] rt_root;
  term_side_t        rt_side;
  // stage 5: dividends
  logic              s5_v_q;
  num_t [LANES-1:0]  s5_num_q;
  logic [ROOT_W-1:0] s5_div_q;
  sign_side_t        s5_side_q;
  // quotient
  logic             dv_v;
  quo_t [LANES-1:0] dv_quo;
  sign_side_t       dv_side;
  // output
  logic      out_v_q;
  out_word_t out_q;

  assign en      = !(out_v_q && stall_i);
  assign stall_o = !en;

  // terms, Shepperd branch choice
  logic signed [TERM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, tr, one;
  logic signed [TERM_W-1:0] t [LANES];
  logic [LANES-1:0]         t_neg;
  mag_t [LANES-1:0]         t_mag;

  always_comb begin
    e00 = TERM_W'(s1_q.elem_00);
    e01 = TERM_W'(s1_q.elem_01);
    e02 = TERM_W'(s1_q.elem_02);
    e10 = TERM_W'(s1_q.elem_10);
    e11 = TERM_W'(s1_q.elem_11);
    e12 = TERM_W'(s1_q.elem_12);
    e20 = TERM_W'(s1_q.elem_20);
    e21 = TERM_W'(s1_q.elem_21);
    e22 = TERM_W'(s1_q.elem_22);
    one = TERM_W'(1) <<< FRAC_BITS;
    tr  = e00 + e11 + e22;
    if (tr >= e00 && tr >= e11 && tr >= e22) begin
      t[0] = e21 - e12;
      t[1] = e02 - e20;
      t[2] = e10 - e01;
      t[3] = one + tr;
    end else if (e00 >= e11 && e00 >= e22) begin
      t[0] = one - (tr - (e00 <<< 1));
      t[1] = e01 + e10;
      t[2] = e02 + e20;
      t[3] = e21 - e12;
    end else if (e11 >= e22) begin
      t[0] = e01 + e10;
      t[1] = one - (tr - (e11 <<< 1));
      t[2] = e12 + e21;
      t[3] = e02 - e20;
    end else begin
      t[0] = e02 + e20;
      t[1] = e12 + e21;
      t[2] = one - (tr - (e22 <<< 1));
      t[3] = e10 - e01;
    end
    for (int l = 0; l < LANES; l++) begin
      t_neg[l] = t[l][TERM_W-1];
      t_mag[l] = t_neg[l] ? MAG_W'(-t[l]) : MAG_W'(t[l]);
    end
  end

  logic [SUM_W-1:0] sum_d;
  always_comb begin
    sum_d = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_d = sum_d + SUM_W'(s3_sq_q[l]);
    end
  end

  logic [RAD_W-1:0] rad;
  assign rad = {s4_sum_q, {(2 * SCALE_BITS){1'b0}}};

  num_t [LANES-1:0] num_d;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_d[l] = (NUM_W'(rt_side.mag[l]) << NUM_SH) + NUM_W'(rt_root >> 1);
    end
  end

  function automatic logic signed [ELEM_W-1:0] sat_f(input logic neg, input quo_t q);
    logic signed [ELEM_W-1:0] r;
    if (neg) begin
      r = (q > quo_t'(32768)) ? 16'sh8000 : ELEM_W'(-q);
    end else begin
      r = (q > quo_t'(32767)) ? 16'sh7fff : ELEM_W'(q);
    end
    return r;
  endfunction

  out_word_t out_d;
  always_comb begin
    out_d.quat_x     = sat_f(dv_side.neg[0], dv_quo[0]);
    out_d.quat_y     = sat_f(dv_side.neg[1], dv_quo[1]);
    out_d.quat_z     = sat_f(dv_side.neg[2], dv_quo[2]);
    out_d.quat_w     = sat_f(dv_side.neg[3], dv_quo[3]);
    out_d.degenerate = dv_side.degen;
    if (dv_side.degen) begin
      out_d.quat_x = '0;
      out_d.quat_y = '0;
      out_d.quat_z = '0;
      out_d.quat_w = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= rt_v;
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= in_i;
      s2_neg_q <= t_neg;
      s2_mag_q <= t_mag;
      s3_neg_q <= s2_neg_q;
      s3_mag_q <= s2_mag_q;
      for (int l = 0; l < LANES; l++) begin
        s3_sq_q[l] <= s2_mag_q[l] * s2_mag_q[l];
      end
      s4_sum_q        <= sum_d;
      s4_side_q.neg   <= s3_neg_q;
      s4_side_q.mag   <= s3_mag_q;
      s4_side_q.degen <= (s3_mag_q == '0);
      s5_num_q        <= num_d;
      s5_div_q        <= rt_root;
      s5_side_q.neg   <= rt_side.neg;
      s5_side_q.degen <= rt_side.degen;
      out_q           <= out_d;
    end
  end

  rmq_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .rad_i   (rad),
    .side_i  (s4_side_q),
    .valid_o (rt_v),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_v_q),
    .num_i   (s5_num_q),
    .div_i   (s5_div_q),
    .side_i  (s5_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  assign valid_o = out_v_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/rmq_isqrt.sv
// rmq_isqrt: pipelined integer square root, one result bit per stage.
// Depends on rmq_pkg.
`default_nettype none

module rmq_isqrt import rmq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  input  wire term_side_t        side_i,
  output logic                   valid_o,
  output logic [ROOT_W-1:0]      root_o,
  output term_side_t             side_o
);

  logic [ROOT_W-1:0] v_q;
  logic [RAD_W-1:0]  rem_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  term_side_t        side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic              v_in;
    term_side_t        side_in;
    logic [RAD_W:0]    trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (2*root + 2^B) * 2^B, root holding only bits above B
    assign trial = ({1'b0, RAD_W'(root_in)} << (B + 1)) | ((RAD_W + 1)'(1) << (2 * B));
    assign fits  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= fits ? (root_in | (ROOT_W'(1) << B)) : root_in;
        side_q[k] <= side_in;
      end
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= fits ? RAD_W'({1'b0, rem_in} - trial) : rem_in;
        end
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/rmq_div.sv
// rmq_div: four-lane pipelined restoring divider with a shared divisor,
// one quotient bit per stage. Depends on rmq_pkg.
`default_nettype none

module rmq_div import rmq_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire num_t [LANES-1:0]         num_i,
  input  wire logic [ROOT_W-1:0]        div_i,
  input  wire sign_side_t               side_i,
  output logic                          valid_o,
  output quo_t [LANES-1:0]              quo_o,
  output sign_side_t                    side_o
);

  logic [Q_W-1:0]    v_q;
  num_t [LANES-1:0]  rem_q  [Q_W-1];
  quo_t [LANES-1:0]  quo_q  [Q_W];
  logic [ROOT_W-1:0] div_q  [Q_W-1];
  sign_side_t        side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    num_t [LANES-1:0]  rem_in;
    quo_t [LANES-1:0]  quo_in;
    logic [ROOT_W-1:0] div_in;
    logic              v_in;
    sign_side_t        side_in;
    num_t              dsh;
    num_t [LANES-1:0]  rem_nx;
    quo_t [LANES-1:0]  quo_nx;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign div_in  = div_i;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign div_in  = div_q[k-1];
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh = NUM_W'(div_in) << B;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_nx[l] = rem_in[l] - dsh;
          quo_nx[l] = quo_in[l] | (Q_W'(1) << B);
        end else begin
          rem_nx[l] = rem_in[l];
          quo_nx[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]  <= quo_nx;
        side_q[k] <= side_in;
      end
    end

    if (k < Q_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_nx;
          div_q[k] <= div_in;
        end
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/rmq_checker.sv
// rmq_checker: port-level assertions for rotation_matrix_to_quaternion, and its bind.
// Depends on rmq_pkg.
`default_nettype none

module rmq_checker import rmq_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      valid_i,
  input wire logic      stall_o,
  input wire in_word_t  in_i,
  input wire logic      valid_o,
  input wire logic      stall_i,
  input wire out_word_t out_o
);

  a_held_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_o))
    else $error("output word dropped or changed while stalled");

  a_held_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable(in_i))
    else $error("input word dropped or changed while stalled");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a stalled output word");

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.degenerate |->
      out_o.quat_x == '0 && out_o.quat_y == '0 && out_o.quat_z == '0 && out_o.quat_w == '0)
    else $error("degenerate word with non-zero components");

  a_unit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_o.degenerate |->
      out_o.quat_x != '0 || out_o.quat_y != '0 || out_o.quat_z != '0 || out_o.quat_w != '0)
    else $error("normalised word is all zero");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (valid_i),
  .stall_o (stall_o),
  .in_i    (in_i),
  .valid_o (valid_o),
  .stall_i (stall_i),
  .out_o   (out_o)
);

`default_nettype wire
